/* sv/pid_pkg.sv */
// Shared constants for the positional PID controller: register map, widths and reset values.
`timescale 1ns / 1ps

package pid_pkg;

  // Width of the configuration byte address and of its register index part.
  localparam int ADDR_W = 5;
  localparam int INDEX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [INDEX_W-1:0] REG_GAIN_P = 3'd0;
  localparam logic [INDEX_W-1:0] REG_GAIN_I = 3'd1;
  localparam logic [INDEX_W-1:0] REG_GAIN_D = 3'd2;
  localparam logic [INDEX_W-1:0] REG_OUTPUT_LIMIT = 3'd3;
  localparam logic [INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;

  // Register widths.
  localparam int GAIN_W = 16;
  localparam int LIMIT_W = 15;

  // Reset values of the limit registers.
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET = 15'd32767;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 15'd2000;

  // Fraction bits of the Q7.8 gains.
  localparam int GAIN_FRAC = 8;

endpackage

/* sv/positional_pid_controller_top.sv */
// Positional PID controller with integral clamping and a symmetric output clamp.
`timescale 1ns / 1ps

// The block takes one input beat (op, target, measured) on a valid/ready channel and
// returns one result beat (drive, saturated) on a second valid/ready channel.
// An op of 0 runs one control step; an op of 1 clears the integral and the last error
// and returns a drive of 0 with saturated low.
// The work runs through four register stages: the input register, the error and
// integral stage, the gain multiplier stage and the result register. A new beat
// may be accepted in every cycle while the receiver does not stall, so the
// sustained rate is one item per clock. The integral and last error are updated
// as each item leaves the input register, which is what allows consecutive items
// to follow one another.
// When the receiver stalls, the whole pipeline holds and item_ready falls in the
// same cycle; the result register keeps its beat until it is taken. Bubbles in the
// pipeline are not squeezed out, but no item is lost or repeated.
// The user must write gains and limits on the APB-style port only while the block is
// idle; the block does not enforce this. pready is always high and reads return the
// stored values, gains sign-extended. Synchronous reset empties the pipeline, zeroes the
// integral, last error and gains and restores the output and integral limits to 32767 and 2000.
module positional_pid_controller_top (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        op,
  input  logic signed [15:0]          target,
  input  logic signed [15:0]          measured,
  // Result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic signed [15:0]          drive,
  output logic                        saturated,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pid_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Configuration registers.
  logic signed [pid_pkg::GAIN_W-1:0] gain_p;
  logic signed [pid_pkg::GAIN_W-1:0] gain_i;
  logic signed [pid_pkg::GAIN_W-1:0] gain_d;
  logic [pid_pkg::LIMIT_W-1:0]       output_limit;
  logic [pid_pkg::LIMIT_W-1:0]       integral_limit;

  logic [pid_pkg::INDEX_W-1:0] reg_index;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[pid_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      output_limit   <= pid_pkg::OUTPUT_LIMIT_RESET;
      integral_limit <= pid_pkg::INTEGRAL_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        pid_pkg::REG_GAIN_P:         gain_p <= pwdata[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_GAIN_I:         gain_i <= pwdata[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_GAIN_D:         gain_d <= pwdata[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_OUTPUT_LIMIT:   output_limit <= pwdata[pid_pkg::LIMIT_W-1:0];
        pid_pkg::REG_INTEGRAL_LIMIT: integral_limit <= pwdata[pid_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data; addresses beyond the register list read as zero.
  always_comb begin
    unique case (reg_index)
      pid_pkg::REG_GAIN_P:         prdata = {{16{gain_p[15]}}, gain_p};
      pid_pkg::REG_GAIN_I:         prdata = {{16{gain_i[15]}}, gain_i};
      pid_pkg::REG_GAIN_D:         prdata = {{16{gain_d[15]}}, gain_d};
      pid_pkg::REG_OUTPUT_LIMIT:   prdata = {17'd0, output_limit};
      pid_pkg::REG_INTEGRAL_LIMIT: prdata = {17'd0, integral_limit};
      default:                     prdata = 32'd0;
    endcase
  end

  // The whole pipeline moves together whenever the result register is free or
  // its beat is being taken.
  logic advance;
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;

  // Input register.
  logic               s0_valid;
  logic               s0_op;
  logic signed [15:0] s0_target;
  logic signed [15:0] s0_measured;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_op       <= op;
      s0_target   <= target;
      s0_measured <= measured;
    end
  end

  // Controller history.
  logic signed [15:0] error_sum;
  logic signed [16:0] previous_error;

  // Error, clamped integral and error difference.
  logic signed [16:0] err_c;
  logic signed [17:0] sum_raw;
  logic signed [17:0] int_lim;
  logic signed [17:0] int_lim_neg;
  logic signed [15:0] sum_clamped;
  logic signed [17:0] derr_c;
  logic signed [16:0] err_next;
  logic signed [15:0] error_sum_next;
  logic signed [17:0] derr_next;

  assign err_c       = {s0_target[15], s0_target} - {s0_measured[15], s0_measured};
  assign sum_raw     = {{2{error_sum[15]}}, error_sum} + {err_c[16], err_c};
  assign int_lim     = {3'd0, integral_limit};
  assign int_lim_neg = -int_lim;
  assign derr_c      = {err_c[16], err_c} - {previous_error[16], previous_error};

  always_comb begin
    priority if (sum_raw > int_lim) begin
      sum_clamped = int_lim[15:0];
    end else if (sum_raw < int_lim_neg) begin
      sum_clamped = int_lim_neg[15:0];
    end else begin
      sum_clamped = sum_raw[15:0];
    end
  end

  // A clear item carries zeros down the pipeline, which yields a drive of 0.
  always_comb begin
    if (s0_op) begin
      err_next       = '0;
      error_sum_next = '0;
      derr_next      = '0;
    end else begin
      err_next       = err_c;
      error_sum_next = sum_clamped;
      derr_next      = derr_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (advance && s0_valid) begin
      error_sum      <= error_sum_next;
      previous_error <= err_next;
    end
  end

  // Error stage register.
  logic               s1_valid;
  logic signed [16:0] s1_err;
  logic signed [15:0] s1_sum;
  logic signed [17:0] s1_derr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_err  <= err_next;
      s1_sum  <= error_sum_next;
      s1_derr <= derr_next;
    end
  end

  // Gain products, each exact at its full width.
  logic signed [32:0] prod_p_c;
  logic signed [31:0] prod_i_c;
  logic signed [33:0] prod_d_c;

  assign prod_p_c = gain_p * s1_err;
  assign prod_i_c = gain_i * s1_sum;
  assign prod_d_c = gain_d * s1_derr;

  logic               s2_valid;
  logic signed [32:0] s2_prod_p;
  logic signed [31:0] s2_prod_i;
  logic signed [33:0] s2_prod_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prod_p <= prod_p_c;
      s2_prod_i <= prod_i_c;
      s2_prod_d <= prod_d_c;
    end
  end

  // Sum, floor shift by the gain fraction and output clamp.
  logic signed [35:0] raw_sum;
  logic signed [35-pid_pkg::GAIN_FRAC:0] raw_shifted;
  logic signed [35-pid_pkg::GAIN_FRAC:0] out_lim;
  logic signed [35-pid_pkg::GAIN_FRAC:0] out_lim_neg;
  logic signed [15:0] drive_next;
  logic               saturated_next;

  assign raw_sum = {{3{s2_prod_p[32]}}, s2_prod_p} + {{4{s2_prod_i[31]}}, s2_prod_i}
                 + {{2{s2_prod_d[33]}}, s2_prod_d};
  // Dropping the low bits of a two's complement value rounds toward minus infinity.
  assign raw_shifted = raw_sum[35:pid_pkg::GAIN_FRAC];
  assign out_lim     = {{(36 - pid_pkg::GAIN_FRAC - pid_pkg::LIMIT_W){1'b0}}, output_limit};
  assign out_lim_neg = -out_lim;

  always_comb begin
    priority if (raw_shifted > out_lim) begin
      drive_next     = out_lim[15:0];
      saturated_next = 1'b1;
    end else if (raw_shifted < out_lim_neg) begin
      drive_next     = out_lim_neg[15:0];
      saturated_next = 1'b1;
    end else begin
      drive_next     = raw_shifted[15:0];
      saturated_next = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive     <= drive_next;
      saturated <= saturated_next;
    end
  end

  // Signed views of the output limit and of the drive for the checks below.
  logic signed [16:0] drive_lim;
  logic signed [16:0] drive_wide;
  assign drive_lim  = {2'b00, output_limit};
  assign drive_wide = {drive[15], drive};

`ifndef SYNTH
  // A clear item leaves no history behind.
  a_clear_wipes_history: assert property (@(posedge clk) disable iff (rst)
    (advance && s0_valid && s0_op) |=> (error_sum == 16'sd0 && previous_error == 17'sd0))
    else $error("clear item did not zero the controller history");

  // A clamped result sits exactly on one of the two limits.
  a_saturated_on_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && saturated) |-> (drive_wide == drive_lim || drive_wide == -drive_lim))
    else $error("saturated drive is not at the output limit");

  // An unclamped result lies within the limits.
  a_unsaturated_in_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !saturated) |-> (drive_wide <= drive_lim && drive_wide >= -drive_lim))
    else $error("unsaturated drive exceeds the output limit");

  // An accepted beat reaches the result register if the pipeline advances without a stall.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) ##1 advance ##1 advance ##1 advance |=> result_valid)
    else $error("accepted beat did not reach the result register");
`endif

endmodule
